// ===== sv/chga_pkg.sv =====
package chga_pkg;

  localparam int NUM_BUCKETS      = 4;
  localparam int BKT_W            = 2;
  localparam int NUM_ENTRIES      = NUM_BUCKETS * NUM_BUCKETS;
  localparam int MAX_BLOCK_COEFFS = 4096;
  localparam int COEFF_W          = 16;
  localparam int CNT_W            = 13;
  localparam int EXCESS_W         = 16;
  localparam int IDX_W            = 4;
  localparam int VALUE_W          = 64;
  localparam int PROD_W           = 2 * CNT_W;
  localparam int IN_DATA_W        = 16;
  localparam int OUT_FIELDS_W     = CNT_W + EXCESS_W + IDX_W + VALUE_W;
  localparam int OUT_DATA_W       = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W        = OUT_DATA_W - OUT_FIELDS_W;
  localparam int QUEUE_DEPTH_DEF  = 4;

  localparam logic [BKT_W-1:0] TOP_BUCKET = BKT_W'(NUM_BUCKETS - 1);

  // tuser codes
  localparam logic REQ_COEFF  = 1'b0;
  localparam logic REQ_READ   = 1'b1;
  localparam logic KIND_STATS = 1'b0;
  localparam logic KIND_ENTRY = 1'b1;

  // classified word as it travels through the queue
  typedef struct packed {
    logic                req;
    logic                neg;
    logic [BKT_W-1:0]    bucket;
    logic [EXCESS_W-1:0] excess;
    logic                last;
  } q_entry_t;

  typedef struct packed {
    logic not_full;
    logic not_empty;
  } q_status_t;

endpackage

// ===== sv/chga_front.sv =====
module chga_front (
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [chga_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic                          in_tlast,
  input  logic                          in_tuser,
  input  chga_pkg::q_status_t           q_status,
  output logic                          push,
  output chga_pkg::q_entry_t            push_entry
);
  import chga_pkg::*;

  logic [COEFF_W-1:0] coeff;
  logic [COEFF_W-1:0] mag;
  logic               neg;

  assign coeff = in_tdata[COEFF_W-1:0];
  assign neg   = coeff[COEFF_W-1];
  // most negative value gives 0x8000, which is the right unsigned magnitude
  assign mag   = neg ? (COEFF_W'(0) - coeff) : coeff;

  assign in_tready = q_status.not_full;
  assign push      = in_tvalid && q_status.not_full;

  always_comb begin
    push_entry.req  = in_tuser;
    push_entry.neg  = neg;
    push_entry.last = in_tlast;
    if (mag > COEFF_W'(TOP_BUCKET)) begin
      push_entry.bucket = TOP_BUCKET;
      push_entry.excess = EXCESS_W'(mag - COEFF_W'(TOP_BUCKET));
    end else begin
      push_entry.bucket = mag[BKT_W-1:0];
      push_entry.excess = '0;
    end
  end

endmodule

// ===== sv/chga_queue.sv =====
module chga_queue #(
  parameter int DEPTH = chga_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  chga_pkg::q_entry_t  push_entry,
  input  logic                pop,
  output chga_pkg::q_entry_t  head,
  output chga_pkg::q_status_t q_status
);
  import chga_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FILL_W = $clog2(DEPTH + 1);

  q_entry_t            slot_r [DEPTH];
  logic [PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [FILL_W-1:0]   fill_r, fill_nxt;

  assign head               = slot_r[rd_ptr_r];
  assign q_status.not_full  = (fill_r != FILL_W'(DEPTH));
  assign q_status.not_empty = (fill_r != '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// ===== sv/chga_back.sv =====
module chga_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  chga_pkg::q_entry_t             head,
  input  chga_pkg::q_status_t            q_status,
  output logic                           pop,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [chga_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                           out_tlast,
  output logic                           out_tuser
);
  import chga_pkg::*;

  localparam logic [1:0] ST_RUN  = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_DUMP = 2'd2;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_ENTRIES - 1);
  localparam logic [CNT_W-1:0] SAT_MAX  = CNT_W'(MAX_BLOCK_COEFFS);

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    sat_inc = (c < SAT_MAX) ? c + 1'b1 : SAT_MAX;
  endfunction

  logic [1:0]            state_r, state_nxt;
  logic [IDX_W-1:0]      cnt_r, cnt_nxt;
  logic [CNT_W-1:0]      signs_r, signs_nxt, signs_upd;
  logic [EXCESS_W-1:0]   excess_r, excess_nxt, excess_upd;
  logic [CNT_W-1:0]      bc_r [NUM_BUCKETS];
  logic [CNT_W-1:0]      bc_nxt [NUM_BUCKETS];
  logic [CNT_W-1:0]      bc_upd [NUM_BUCKETS];
  // snapshots of the finished block's counts, rotated so that slot 0 is the operand
  logic [CNT_W-1:0]      col_r [NUM_BUCKETS];
  logic [CNT_W-1:0]      col_nxt [NUM_BUCKETS];
  logic [CNT_W-1:0]      row_r [NUM_BUCKETS];
  logic [CNT_W-1:0]      row_nxt [NUM_BUCKETS];
  logic                  mul_en;
  logic [PROD_W-1:0]     prod_r;
  logic                  prod_vld_r;
  // matrix kept as a ring: slot 0 is the entry being added to or read out
  logic [VALUE_W-1:0]    gram_r [NUM_ENTRIES];
  logic                  dump_shift;
  logic                  out_free;
  logic                  out_vld_r, out_vld_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic                  out_last_r, out_last_nxt;
  logic                  out_kind_r, out_kind_nxt;

  assign out_free   = !out_vld_r || out_tready;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_kind_r;

  always_comb begin
    signs_upd  = head.neg ? sat_inc(signs_r) : signs_r;
    excess_upd = excess_r + head.excess;
    for (int i = 0; i < NUM_BUCKETS; i++) begin
      bc_upd[i] = (head.bucket == BKT_W'(i)) ? sat_inc(bc_r[i]) : bc_r[i];
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    signs_nxt    = signs_r;
    excess_nxt   = excess_r;
    bc_nxt       = bc_r;
    col_nxt      = col_r;
    row_nxt      = row_r;
    pop          = 1'b0;
    mul_en       = 1'b0;
    dump_shift   = 1'b0;
    out_vld_nxt  = out_vld_r && !out_tready;
    out_data_nxt = out_data_r;
    out_last_nxt = out_last_r;
    out_kind_nxt = out_kind_r;
    case (state_r)
      ST_RUN: begin
        if (q_status.not_empty) begin
          if (head.req == REQ_READ) begin
            pop       = 1'b1;
            cnt_nxt   = '0;
            state_nxt = ST_DUMP;
          end else if (!head.last || out_free) begin
            pop = 1'b1;
            if (head.last) begin
              signs_nxt    = '0;
              excess_nxt   = '0;
              col_nxt      = bc_upd;
              row_nxt      = bc_upd;
              cnt_nxt      = '0;
              state_nxt    = ST_MUL;
              out_vld_nxt  = 1'b1;
              out_kind_nxt = KIND_STATS;
              out_last_nxt = 1'b1;
              out_data_nxt = {OUT_PAD_W'(0), VALUE_W'(0), IDX_W'(0), excess_upd, signs_upd};
              for (int i = 0; i < NUM_BUCKETS; i++) begin
                bc_nxt[i] = '0;
              end
            end else begin
              signs_nxt  = signs_upd;
              excess_nxt = excess_upd;
              bc_nxt     = bc_upd;
            end
          end
        end
      end
      ST_MUL: begin
        // row-major walk: column rotates every word, row every NUM_BUCKETS words
        mul_en = 1'b1;
        for (int i = 0; i < NUM_BUCKETS; i++) begin
          col_nxt[i] = col_r[(i + 1) % NUM_BUCKETS];
        end
        if (cnt_r[BKT_W-1:0] == TOP_BUCKET) begin
          for (int i = 0; i < NUM_BUCKETS; i++) begin
            row_nxt[i] = row_r[(i + 1) % NUM_BUCKETS];
          end
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST_IDX) begin
          state_nxt = ST_RUN;
        end
      end
      ST_DUMP: begin
        if (out_free) begin
          dump_shift   = 1'b1;
          out_vld_nxt  = 1'b1;
          out_kind_nxt = KIND_ENTRY;
          out_last_nxt = (cnt_r == LAST_IDX);
          out_data_nxt = {OUT_PAD_W'(0), gram_r[0], cnt_r, EXCESS_W'(0), CNT_W'(0)};
          cnt_nxt      = cnt_r + 1'b1;
          if (cnt_r == LAST_IDX) begin
            state_nxt = ST_RUN;
          end
        end
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_RUN;
      cnt_r      <= '0;
      signs_r    <= '0;
      excess_r   <= '0;
      prod_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
      for (int i = 0; i < NUM_BUCKETS; i++) begin
        bc_r[i] <= '0;
      end
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        gram_r[i] <= '0;
      end
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      signs_r    <= signs_nxt;
      excess_r   <= excess_nxt;
      prod_vld_r <= mul_en;
      out_vld_r  <= out_vld_nxt;
      bc_r       <= bc_nxt;
      if (prod_vld_r || dump_shift) begin
        for (int i = 0; i < NUM_ENTRIES - 1; i++) begin
          gram_r[i] <= gram_r[i + 1];
        end
        gram_r[NUM_ENTRIES-1] <= prod_vld_r ? gram_r[0] + VALUE_W'(prod_r) : gram_r[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    col_r      <= col_nxt;
    row_r      <= row_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
    out_kind_r <= out_kind_nxt;
    if (mul_en) begin
      prod_r <= PROD_W'(col_r[0] * row_r[0]);
    end
  end

endmodule

// ===== sv/coeff_histogram_gram_accumulator.sv =====
// Coefficient statistics unit. Signed 16-bit coefficients arrive on the in_ stream, one
// word per cycle while the queue has room, with tlast marking the end of a block; a
// word with tuser set asks for the 4x4 matrix to be read out. Each coefficient is
// classified on entry (sign, magnitude bucket 0..3, excess above 3) and queued, so the
// input keeps flowing while the back end is busy. The last coefficient of a block emits
// one statistics word (sign count, excess sum) and then ties up the back end while a
// single 13x13 multiplier walks the outer product of the bucket counts into the
// 64-bit matrix accumulators, one entry per cycle. A read-out request emits 16 matrix
// words in row-major order, one per cycle when out_tready stays high, the last with
// tlast set. The queue (QUEUE_DEPTH words) absorbs input during these phases.
module coeff_histogram_gram_accumulator #(
  parameter int QUEUE_DEPTH = chga_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [chga_pkg::IN_DATA_W-1:0]  in_tdata,   // [15:0] coeff_value
  input  logic                            in_tlast,   // block_last
  input  logic                            in_tuser,   // req_type
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [12:0] sign_count, [28:13] excess_sum, [32:29] entry_index, [96:33] entry_value
  output logic [chga_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                            out_tlast,  // run_last
  output logic                            out_tuser   // result_kind
);
  import chga_pkg::*;

  q_status_t q_status;
  q_entry_t  push_entry;
  q_entry_t  head;
  logic      push;
  logic      pop;

  chga_front u_front (
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .q_status   (q_status),
    .push       (push),
    .push_entry (push_entry)
  );

  chga_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .q_status   (q_status)
  );

  chga_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .q_status   (q_status),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== sv/chga_checker.sv =====
module chga_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [chga_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                            out_tlast,
  input logic                            out_tuser
);
  import chga_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast)
      && $stable(out_tuser))
    else $error("result word changed while stalled");

  // statistics are a run of one word
  a_stats_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_STATS |-> out_tlast)
    else $error("statistics word without tlast");

  a_stats_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_STATS |-> out_tdata[96:29] == '0)
    else $error("statistics word carries matrix fields");

  a_entry_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_ENTRY |-> out_tdata[28:0] == '0)
    else $error("matrix word carries block fields");

  // a matrix run ends only on the final entry index
  a_entry_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_ENTRY |-> out_tlast == (out_tdata[32:29] == 4'd15))
    else $error("matrix run tlast misplaced");

endmodule

bind coeff_histogram_gram_accumulator chga_checker u_chga_checker (.*);

// ===== dv/coeff_histogram_gram_accumulator_tb.sv =====
`timescale 1ns / 100ps

module coeff_histogram_gram_accumulator_tb;
  import chga_pkg::*;

  localparam int EXC_LSB   = CNT_W;
  localparam int IDX_LSB   = EXC_LSB + EXCESS_W;
  localparam int VAL_LSB   = IDX_LSB + IDX_W;
  localparam int IDLE_LIMIT = 4000;   // longest stall plus back-end walk, many times over
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_WORDS = 440;

  typedef struct {
    logic                kind;
    logic [CNT_W-1:0]    signs;
    logic [EXCESS_W-1:0] excess;
    logic [IDX_W-1:0]    idx;
    logic [VALUE_W-1:0]  value;
    logic                last;
  } result_t;

  typedef struct packed {
    logic                req;
    logic [15:0]         coeff;
    logic                last;
    logic                fixed;   // typed-in expectation below is used
    logic [CNT_W-1:0]    signs;
    logic [EXCESS_W-1:0] excess;
  } dir_row_t;

  localparam int DIR_ROWS = 22;
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    '{REQ_READ,  16'h0000, 1'b0, 1'b1, 13'd0, 16'd0},      // matrix empty after reset
    '{REQ_COEFF, 16'h0000, 1'b1, 1'b1, 13'd0, 16'd0},
    '{REQ_COEFF, 16'h7FFF, 1'b1, 1'b1, 13'd0, 16'd32764},
    '{REQ_COEFF, 16'h8000, 1'b1, 1'b1, 13'd1, 16'd32765},  // most negative
    '{REQ_COEFF, 16'hFFFF, 1'b1, 1'b1, 13'd1, 16'd0},
    '{REQ_COEFF, 16'h0001, 1'b0, 1'b0, 13'd0, 16'd0},
    '{REQ_COEFF, 16'hFFFE, 1'b0, 1'b0, 13'd0, 16'd0},
    '{REQ_COEFF, 16'h0003, 1'b0, 1'b0, 13'd0, 16'd0},
    '{REQ_COEFF, 16'hFFFC, 1'b1, 1'b1, 13'd2, 16'd1},
    '{REQ_COEFF, 16'h7FFF, 1'b0, 1'b0, 13'd0, 16'd0},
    '{REQ_COEFF, 16'h7FFF, 1'b0, 1'b0, 13'd0, 16'd0},
    '{REQ_COEFF, 16'h7FFF, 1'b1, 1'b1, 13'd0, 16'd32756},  // excess wraps
    '{REQ_COEFF, 16'h0005, 1'b0, 1'b0, 13'd0, 16'd0},
    '{REQ_READ,  16'hFFFF, 1'b1, 1'b0, 13'd0, 16'd0},      // read-out inside an open block
    '{REQ_COEFF, 16'hFFFB, 1'b1, 1'b1, 13'd1, 16'd4},
    '{REQ_READ,  16'h0000, 1'b0, 1'b0, 13'd0, 16'd0},
    '{REQ_COEFF, 16'h8000, 1'b0, 1'b0, 13'd0, 16'd0},
    '{REQ_COEFF, 16'h8001, 1'b1, 1'b1, 13'd2, 16'd65529},
    '{REQ_COEFF, 16'h0004, 1'b0, 1'b0, 13'd0, 16'd0},
    '{REQ_COEFF, 16'h8000, 1'b0, 1'b0, 13'd0, 16'd0},
    '{REQ_COEFF, 16'h7FFF, 1'b1, 1'b0, 13'd0, 16'd0},
    '{REQ_READ,  16'hFFFF, 1'b1, 1'b0, 13'd0, 16'd0}
  };

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // [15:0] coeff_value
  logic                  in_tlast = 1'b0; // block_last
  logic                  in_tuser = 1'b0; // req_type
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // [12:0] sign_count, [28:13] excess_sum, [32:29] entry_index, [96:33] entry_value
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;       // run_last
  logic                  out_tuser;       // result_kind

  // shadow of the block's statistics state
  logic [CNT_W-1:0]    hist_counts [NUM_BUCKETS];
  logic [CNT_W-1:0]    open_signs;
  logic [EXCESS_W-1:0] open_excess;
  logic [VALUE_W-1:0]  gram [NUM_ENTRIES];

  result_t     due_words[$];
  int unsigned errors = 0;
  int unsigned idle_cycles = 0;
  int unsigned stall_left = 0;
  bit          in_calm = 1'b0;
  bit          out_calm = 1'b0;

  coeff_histogram_gram_accumulator DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [CNT_W-1:0] sat_count(logic [CNT_W-1:0] c);
    return (c < CNT_W'(MAX_BLOCK_COEFFS)) ? c + 1'b1 : CNT_W'(MAX_BLOCK_COEFFS);
  endfunction

  // mostly short gaps, a few long ones; none in a calm stretch
  function automatic int unsigned pick_gap(bit calm);
    int unsigned r;
    r = $urandom_range(99);
    if (calm || r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic void clear_histogram();
    for (int b = 0; b < NUM_BUCKETS; b++) hist_counts[b] = '0;
    open_signs  = '0;
    open_excess = '0;
  endfunction

  // updates the shadow state with one accepted word and queues the words it causes
  function automatic void account_word(logic req, logic [15:0] coeff, logic last, logic fixed,
                                       logic [CNT_W-1:0] fix_signs,
                                       logic [EXCESS_W-1:0] fix_excess);
    result_t          r;
    logic [16:0]      mag;
    logic [BKT_W-1:0] bkt;
    if (req == REQ_READ) begin
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        r.kind   = KIND_ENTRY;
        r.signs  = '0;
        r.excess = '0;
        r.idx    = IDX_W'(i);
        r.value  = fixed ? '0 : gram[i];
        r.last   = (i == NUM_ENTRIES - 1);
        due_words.push_back(r);
      end
      return;
    end
    mag = coeff[15] ? 17'h10000 - {1'b0, coeff} : {1'b0, coeff};
    if (coeff[15]) open_signs = sat_count(open_signs);
    if (mag > 17'(TOP_BUCKET)) begin
      open_excess = open_excess + EXCESS_W'(mag - 17'(TOP_BUCKET));
      bkt = TOP_BUCKET;
    end else begin
      bkt = mag[BKT_W-1:0];
    end
    hist_counts[bkt] = sat_count(hist_counts[bkt]);
    if (!last) return;
    r.kind   = KIND_STATS;
    r.signs  = fixed ? fix_signs : open_signs;
    r.excess = fixed ? fix_excess : open_excess;
    r.idx    = '0;
    r.value  = '0;
    r.last   = 1'b1;
    due_words.push_back(r);
    for (int y = 0; y < NUM_BUCKETS; y++)
      for (int x = 0; x < NUM_BUCKETS; x++)
        gram[y * NUM_BUCKETS + x] += VALUE_W'(hist_counts[x]) * VALUE_W'(hist_counts[y]);
    clear_histogram();
  endfunction

  task automatic send_word(input logic req, input logic [15:0] coeff, input logic last,
                           input logic fixed = 1'b0,
                           input logic [CNT_W-1:0] fix_signs = '0,
                           input logic [EXCESS_W-1:0] fix_excess = '0);
    int unsigned gap;
    gap = pick_gap(in_calm);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= coeff;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    account_word(req, coeff, last, fixed, fix_signs, fix_excess);
  endtask

  function automatic logic [15:0] random_coeff();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 40) return 16'($urandom_range(8)) - 16'd4;
    if (r < 50) begin
      case ($urandom_range(4))
        0:       return 16'h8000;
        1:       return 16'h7FFF;
        2:       return 16'h8001;
        3:       return 16'hFFFF;
        default: return 16'h0000;
      endcase
    end
    return 16'($urandom);
  endfunction

  task automatic check_field(input string what, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, what, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (due_words.size() == 0) begin
        $display("%0t: unexpected result word: expected none, got tuser %0b tdata %0h",
                 $time, out_tuser, out_tdata);
        errors++;
      end else begin
        want = due_words.pop_front();
        check_field("result_kind", 64'(want.kind),   64'(out_tuser));
        check_field("sign_count",  64'(want.signs),  64'(out_tdata[EXC_LSB-1:0]));
        check_field("excess_sum",  64'(want.excess), 64'(out_tdata[IDX_LSB-1:EXC_LSB]));
        check_field("entry_index", 64'(want.idx),    64'(out_tdata[VAL_LSB-1:IDX_LSB]));
        check_field("entry_value", want.value,       out_tdata[VAL_LSB+VALUE_W-1:VAL_LSB]);
        check_field("run_last",    64'(want.last),   64'(out_tlast));
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else begin
      out_tready <= 1'b1;
      stall_left = ($urandom_range(2) == 0) ? pick_gap(out_calm) : 0;
      if ($urandom_range(199) == 0) out_calm = !out_calm;
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    int unsigned sent;
    int unsigned len;
    for (int i = 0; i < NUM_ENTRIES; i++) gram[i] = '0;
    clear_histogram();
    sent = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++)
      send_word(DIRECTED[i].req, DIRECTED[i].coeff, DIRECTED[i].last, DIRECTED[i].fixed,
                DIRECTED[i].signs, DIRECTED[i].excess);

    while (sent < RANDOM_WORDS) begin
      if ($urandom_range(29) == 0) in_calm = !in_calm;
      case ($urandom_range(19))
        0, 1:    len = $urandom_range(40, 9);
        2:       len = $urandom_range(150, 41);
        default: len = $urandom_range(8, 1);
      endcase
      for (int k = 0; k < len; k++) begin
        // read-outs land between and inside blocks; their payload is junk
        if ($urandom_range(24) == 0) begin
          send_word(REQ_READ, 16'($urandom), 1'($urandom));
          sent++;
        end
        send_word(REQ_COEFF, random_coeff(), k == len - 1);
        sent++;
      end
    end

    send_word(REQ_READ, 16'($urandom), 1'($urandom));
    in_tvalid <= 1'b0;

    while (due_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
